@@ sv/lkvc_pkg.sv @@
// Shared types and constants for the LRU key-value cache.
// No dependencies; used by the interfaces, the cache and the testbench.
package lkvc_pkg;

  // Width and reset value of the capacity register.
  localparam int unsigned CAP_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

endpackage

@@ sv/lkvc_if.sv @@
// Valid/ready channel interfaces for the LRU key-value cache.
// Depends on lkvc_pkg for the opcode type.
interface lkvc_req_if #(
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  lkvc_pkg::op_e         opcode;
  logic [KEY_BITS-1:0]   lookup_key;
  logic [VALUE_BITS-1:0] write_value;

  modport source (output valid, output opcode, output lookup_key, output write_value,
                  input ready);
  modport sink   (input valid, input opcode, input lookup_key, input write_value,
                  output ready);
endinterface

interface lkvc_rsp_if #(
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] read_value;
  logic                  evicted;
  logic [KEY_BITS-1:0]   evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

@@ sv/lkvc_lookup.sv @@
// Parallel key match and LRU victim select over all cache entries.
// Depends on nothing but its parameters; instantiated by lru_key_value_cache.
module lkvc_lookup #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 16,
  parameter int unsigned VALUE_BITS  = 32,
  parameter int unsigned RW          = 4
) (
  input  logic [MAX_ENTRIES-1:0] valid_i,
  input  logic [KEY_BITS-1:0]    keys_i   [MAX_ENTRIES],
  input  logic [VALUE_BITS-1:0]  values_i [MAX_ENTRIES],
  input  logic [RW-1:0]          ranks_i  [MAX_ENTRIES],
  input  logic [KEY_BITS-1:0]    key_i,
  input  logic [RW-1:0]          last_rank_i,
  output logic [MAX_ENTRIES-1:0] match_o,
  output logic [MAX_ENTRIES-1:0] lru_o,
  output logic [VALUE_BITS-1:0]  hit_value_o,
  output logic [RW-1:0]          hit_rank_o,
  output logic [KEY_BITS-1:0]    lru_key_o
);

  // Valid keys are unique and valid ranks form a permutation, so both
  // vectors are one-hot (or zero) and an OR mux selects the entry.
  always_comb begin
    hit_value_o = '0;
    hit_rank_o  = '0;
    lru_key_o   = '0;
    for (int unsigned i = 0; i < MAX_ENTRIES; i++) begin
      match_o[i] = valid_i[i] && (keys_i[i] == key_i);
      lru_o[i]   = valid_i[i] && (ranks_i[i] == last_rank_i);
      if (match_o[i]) begin
        hit_value_o = hit_value_o | values_i[i];
        hit_rank_o  = hit_rank_o | ranks_i[i];
      end
      if (lru_o[i]) begin
        lru_key_o = lru_key_o | keys_i[i];
      end
    end
  end

endmodule

@@ sv/lru_key_value_cache.sv @@
// Fully associative key-value cache with least-recently-used replacement.
// Depends on lkvc_pkg, lkvc_req_if / lkvc_rsp_if and lkvc_lookup.
//
//   channel | dir | payload                                      | beat when
//   req_i   | in  | opcode, lookup_key, write_value              | valid & ready
//   rsp_o   | out | hit, read_value, evicted, evicted_key        | valid & ready
//   cfg     | in  | cfg_wdata_i (capacity_in_use)                | cfg_we_i
//
// One request per cycle sustained while the response is not stalled; response valid
// follows the request beat through the request register, then the response register.
// The entry state is updated as a request moves into the response register,
// so the next request already sees it.
// A stalled response holds the request register; req ready drops only then.
// Reset clears valid bits, the fill count and sets capacity to 16.
module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 16,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lkvc_pkg::CAP_BITS-1:0] cfg_wdata_i,
  lkvc_req_if.sink                      req_i,
  lkvc_rsp_if.source                    rsp_o
);

  localparam int unsigned RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned UW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EW = (UW > lkvc_pkg::CAP_BITS) ? UW : lkvc_pkg::CAP_BITS;

  // Configuration
  logic [lkvc_pkg::CAP_BITS-1:0] cap_q;

  // Entry state
  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [KEY_BITS-1:0]    key_q   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0]  value_q [MAX_ENTRIES];
  logic [RW-1:0]          rank_q  [MAX_ENTRIES];
  logic [UW-1:0]          used_q, used_d;

  // Request register
  logic                  in_vld_q, in_vld_d;
  lkvc_pkg::op_e         in_op_q;
  logic [KEY_BITS-1:0]   in_key_q;
  logic [VALUE_BITS-1:0] in_val_q;

  // Response register
  logic                  out_vld_q, out_vld_d;
  logic                  out_hit_q;
  logic [VALUE_BITS-1:0] out_rd_q;
  logic                  out_ev_q;
  logic [KEY_BITS-1:0]   out_evk_q;

  logic                   accept, advance;
  logic [MAX_ENTRIES-1:0] match, lru, target;
  logic [VALUE_BITS-1:0]  hit_value;
  logic [RW-1:0]          hit_rank, last_rank, pivot, slot;
  logic [KEY_BITS-1:0]    lru_key;
  logic [EW-1:0]          eff_cap;
  logic                   is_put, hit, can_fill, do_fill, do_evict, do_update;

  assign advance     = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || advance;
  assign accept      = req_i.valid && req_i.ready;

  assign in_vld_d  = accept ? 1'b1 : (advance ? 1'b0 : in_vld_q);
  assign out_vld_d = advance ? 1'b1 : (rsp_o.ready ? 1'b0 : out_vld_q);

  assign last_rank = RW'(UW'(used_q - UW'(1)));
  assign slot      = RW'(used_q);

  lkvc_lookup #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS),
    .RW          (RW)
  ) u_lookup (
    .valid_i     (valid_q),
    .keys_i      (key_q),
    .values_i    (value_q),
    .ranks_i     (rank_q),
    .key_i       (in_key_q),
    .last_rank_i (last_rank),
    .match_o     (match),
    .lru_o       (lru),
    .hit_value_o (hit_value),
    .hit_rank_o  (hit_rank),
    .lru_key_o   (lru_key)
  );

  // Capacity of zero acts as one, anything above the entry count as full size.
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = EW'(1);
    end else if (EW'(cap_q) > EW'(MAX_ENTRIES)) begin
      eff_cap = EW'(MAX_ENTRIES);
    end else begin
      eff_cap = EW'(cap_q);
    end
  end

  assign is_put    = (in_op_q == lkvc_pkg::OP_PUT);
  assign hit       = |match;
  // Entries fill in index order and are never freed, so the next free slot
  // is the fill count itself.
  assign can_fill  = EW'(used_q) < eff_cap;
  assign do_fill   = is_put && !hit && can_fill;
  assign do_evict  = is_put && !hit && !can_fill;
  assign do_update = advance && (hit || is_put);
  assign pivot     = hit ? hit_rank : last_rank;

  always_comb begin
    for (int unsigned i = 0; i < MAX_ENTRIES; i++) begin
      if (hit) begin
        target[i] = match[i];
      end else if (do_fill) begin
        target[i] = (RW'(i) == slot);
      end else begin
        target[i] = lru[i];
      end
    end
  end

  assign valid_d = (advance && do_fill) ? (valid_q | target) : valid_q;
  assign used_d  = (advance && do_fill) ? UW'(used_q + UW'(1)) : used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= lkvc_pkg::CAP_RESET;
      valid_q   <= '0;
      used_q    <= '0;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      valid_q   <= valid_d;
      used_q    <= used_d;
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_op_q  <= req_i.opcode;
      in_key_q <= req_i.lookup_key;
      in_val_q <= req_i.write_value;
    end
    if (advance) begin
      out_hit_q <= hit;
      out_rd_q  <= (hit && !is_put) ? hit_value : '0;
      out_ev_q  <= do_evict;
      out_evk_q <= do_evict ? lru_key : '0;
    end
  end

  // Entry update: target goes to rank 0, younger valid entries age by one.
  // A fill ages every valid entry.
  always_ff @(posedge clk_i) begin
    if (do_update) begin
      for (int unsigned i = 0; i < MAX_ENTRIES; i++) begin
        if (target[i]) begin
          rank_q[i] <= '0;
          if (is_put) begin
            key_q[i]   <= in_key_q;
            value_q[i] <= in_val_q;
          end
        end else if (valid_q[i] && (do_fill || (rank_q[i] < pivot))) begin
          rank_q[i] <= RW'(rank_q[i] + RW'(1));
        end
      end
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.read_value  = out_rd_q;
  assign rsp_o.evicted     = out_ev_q;
  assign rsp_o.evicted_key = out_evk_q;

endmodule

@@ sv/lkvc_checker.sv @@
// Port-level checks for lru_key_value_cache, attached with bind.
// Depends only on the top level's ports.
module lkvc_checker #(
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  rsp_valid_i,
  input logic                  rsp_ready_i,
  input logic                  rsp_hit_i,
  input logic [VALUE_BITS-1:0] rsp_read_value_i,
  input logic                  rsp_evicted_i,
  input logic [KEY_BITS-1:0]   rsp_evicted_key_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(rsp_hit_i) && $stable(rsp_read_value_i) &&
      $stable(rsp_evicted_i) && $stable(rsp_evicted_key_i))
    else $error("response payload changed while stalled");

  // Eviction only happens on a put of a key that was absent.
  a_evict_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_evicted_i |-> !rsp_hit_i && (rsp_read_value_i == '0))
    else $error("eviction reported together with a hit or data");

  a_evk_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_evicted_i |-> (rsp_evicted_key_i == '0))
    else $error("evicted key nonzero without eviction");

  a_data_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_read_value_i != '0) |-> rsp_hit_i)
    else $error("read data returned on a miss");

endmodule

bind lru_key_value_cache lkvc_checker #(
  .KEY_BITS   (KEY_BITS),
  .VALUE_BITS (VALUE_BITS)
) u_lkvc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_hit_i         (rsp_o.hit),
  .rsp_read_value_i  (rsp_o.read_value),
  .rsp_evicted_i     (rsp_o.evicted),
  .rsp_evicted_key_i (rsp_o.evicted_key)
);

@@ verif/tb_lru_key_value_cache.sv @@
// Self-checking testbench for lru_key_value_cache: a directed table, then random
// get/put traffic in phases of changing capacity, against an LRU predictor.
// Depends on lkvc_pkg, lkvc_req_if / lkvc_rsp_if and the cache RTL.
module tb_lru_key_value_cache;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES      = 16;
  localparam int unsigned KEY_W        = 16;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 120;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned QUIET_LIMIT  = 2000;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } cache_rsp_t;

  typedef struct packed {
    logic                          set_cap;
    logic [lkvc_pkg::CAP_BITS-1:0] cap;
    lkvc_pkg::op_e                 op;
    logic [KEY_W-1:0]              key;
    logic [VAL_W-1:0]              wval;
    logic                          fixed;
    cache_rsp_t                    fixed_rsp;
  } stim_row_t;

  localparam cache_rsp_t NO_RSP = '{1'b0, 32'h0, 1'b0, 16'h0};
  localparam int unsigned ROWS = 21;

  // Rows with fixed = 1 carry the expected response typed in; the rest use the predictor.
  localparam stim_row_t DIRECTED [0:ROWS-1] = '{
    '{1'b0, 5'd0,  lkvc_pkg::OP_GET, 16'h0000, 32'hDEADBEEF, 1'b1, '{1'b0, 32'h0, 1'b0, 16'h0}},
    '{1'b0, 5'd0,  lkvc_pkg::OP_PUT, 16'hFFFF, 32'hFFFFFFFF, 1'b1, '{1'b0, 32'h0, 1'b0, 16'h0}},
    '{1'b0, 5'd0,  lkvc_pkg::OP_GET, 16'hFFFF, 32'h00000000, 1'b1,
      '{1'b1, 32'hFFFFFFFF, 1'b0, 16'h0}},
    '{1'b0, 5'd0,  lkvc_pkg::OP_PUT, 16'h0000, 32'h00000000, 1'b1, '{1'b0, 32'h0, 1'b0, 16'h0}},
    '{1'b0, 5'd0,  lkvc_pkg::OP_PUT, 16'hFFFF, 32'h12345678, 1'b1, '{1'b1, 32'h0, 1'b0, 16'h0}},
    '{1'b0, 5'd0,  lkvc_pkg::OP_GET, 16'h0000, 32'hFFFFFFFF, 1'b1, '{1'b1, 32'h0, 1'b0, 16'h0}},
    // capacity dropped below the fill count: new keys replace, count stays
    '{1'b1, 5'd1,  lkvc_pkg::OP_PUT, 16'h1234, 32'hAAAA5555, 1'b0, NO_RSP},
    '{1'b0, 5'd0,  lkvc_pkg::OP_PUT, 16'h5678, 32'h5555AAAA, 1'b0, NO_RSP},
    '{1'b0, 5'd0,  lkvc_pkg::OP_GET, 16'h1234, 32'h00000000, 1'b0, NO_RSP},
    // zero capacity behaves as one
    '{1'b1, 5'd0,  lkvc_pkg::OP_PUT, 16'h0F0F, 32'h0F0F0F0F, 1'b0, NO_RSP},
    '{1'b0, 5'd0,  lkvc_pkg::OP_GET, 16'h5678, 32'h00000000, 1'b0, NO_RSP},
    // above the entry count behaves as full size
    '{1'b1, 5'd31, lkvc_pkg::OP_PUT, 16'h8000, 32'h80000000, 1'b0, NO_RSP},
    '{1'b0, 5'd0,  lkvc_pkg::OP_PUT, 16'h0001, 32'h00000001, 1'b0, NO_RSP},
    '{1'b0, 5'd0,  lkvc_pkg::OP_PUT, 16'h7FFF, 32'h7FFFFFFF, 1'b0, NO_RSP},
    '{1'b0, 5'd0,  lkvc_pkg::OP_GET, 16'h8000, 32'h00000000, 1'b0, NO_RSP},
    '{1'b1, 5'd16, lkvc_pkg::OP_PUT, 16'h00FF, 32'hFFFF0000, 1'b0, NO_RSP},
    '{1'b0, 5'd0,  lkvc_pkg::OP_GET, 16'h0F0F, 32'h00000000, 1'b0, NO_RSP},
    '{1'b0, 5'd0,  lkvc_pkg::OP_GET, 16'h4242, 32'h00000000, 1'b0, NO_RSP},
    '{1'b1, 5'd2,  lkvc_pkg::OP_PUT, 16'h3333, 32'h33333333, 1'b0, NO_RSP},
    '{1'b0, 5'd0,  lkvc_pkg::OP_PUT, 16'h4444, 32'h44444444, 1'b0, NO_RSP},
    '{1'b0, 5'd0,  lkvc_pkg::OP_GET, 16'h0001, 32'h00000000, 1'b0, NO_RSP}
  };

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [lkvc_pkg::CAP_BITS-1:0] cfg_wdata_i;

  lkvc_req_if #(.KEY_BITS(KEY_W), .VALUE_BITS(VAL_W)) req_bus ();
  lkvc_rsp_if #(.KEY_BITS(KEY_W), .VALUE_BITS(VAL_W)) rsp_bus ();

  lru_key_value_cache #(
    .MAX_ENTRIES(ENTRIES),
    .KEY_BITS   (KEY_W),
    .VALUE_BITS (VAL_W)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  // Predictor state
  logic                          line_valid [ENTRIES];
  logic [KEY_W-1:0]              line_key   [ENTRIES];
  logic [VAL_W-1:0]              line_value [ENTRIES];
  int unsigned                   line_rank  [ENTRIES];
  int unsigned                   lines_used;
  logic [lkvc_pkg::CAP_BITS-1:0] cap_reg;

  cache_rsp_t  pending_rsp [$];
  int unsigned fail_count;
  int unsigned quiet_cycles;
  bit          idle_on;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void make_recent(int unsigned idx, int unsigned old_rank);
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      if (i != idx && line_valid[i] && line_rank[i] < old_rank) line_rank[i]++;
    end
    line_rank[idx] = 0;
  endfunction

  function automatic cache_rsp_t predict_access(lkvc_pkg::op_e op, logic [KEY_W-1:0] key,
                                                logic [VAL_W-1:0] wval);
    cache_rsp_t  r;
    int          found;
    int          slot;
    int          victim;
    int unsigned victim_rank;
    int unsigned eff_cap;
    r = NO_RSP;
    found = -1;
    slot = -1;
    victim = -1;
    victim_rank = 0;
    eff_cap = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
    for (int i = 0; i < ENTRIES; i++) begin
      if (found < 0 && line_valid[i] && line_key[i] == key) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      if (op == lkvc_pkg::OP_PUT) line_value[found] = wval;
      else r.read_value = line_value[found];
      make_recent(found, line_rank[found]);
    end else if (op == lkvc_pkg::OP_PUT) begin
      if (lines_used < eff_cap) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !line_valid[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        line_valid[slot] = 1'b1;
        line_key[slot]   = key;
        line_value[slot] = wval;
        lines_used++;
        make_recent(slot, 32'hFFFF_FFFF);
      end else begin
        // oldest rank wins, lowest index on a tie
        for (int i = 0; i < ENTRIES; i++) begin
          if (line_valid[i] && (victim < 0 || line_rank[i] > victim_rank)) begin
            victim = i;
            victim_rank = line_rank[i];
          end
        end
        if (victim >= 0) begin
          r.evicted     = 1'b1;
          r.evicted_key = line_key[victim];
          line_key[victim]   = key;
          line_value[victim] = wval;
          make_recent(victim, victim_rank);
        end
      end
    end
    return r;
  endfunction

  task automatic issue_request(lkvc_pkg::op_e op, logic [KEY_W-1:0] key,
                               logic [VAL_W-1:0] wval,
                               bit use_fixed, cache_rsp_t fixed_rsp);
    cache_rsp_t predicted;
    while (idle_on && $urandom_range(99) < 13) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid       <= 1'b1;
    req_bus.opcode      <= op;
    req_bus.lookup_key  <= key;
    req_bus.write_value <= wval;
    // ready seen at the falling edge decides the beat at the next rising edge
    do @(negedge clk_i); while (!req_bus.ready);
    predicted = predict_access(op, key, wval);
    pending_rsp.push_back(use_fixed ? fixed_rsp : predicted);
    @(posedge clk_i);
  endtask

  task automatic drain_responses();
    req_bus.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [lkvc_pkg::CAP_BITS-1:0] cap);
    drain_responses();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_reg = cap;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Response side: random back-pressure plus one long hold-off on request.
  initial begin : rsp_driver
    int unsigned hold_left;
    hold_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_bus.ready <= !(idle_on && $urandom_range(99) < 13);
      end
    end
  end

  always @(negedge clk_i) begin : rsp_check
    cache_rsp_t want;
    if (rst_ni) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (pending_rsp.size() == 0) begin
          $error("unexpected response beat: hit %b read_value %h evicted %b evicted_key %h",
                 rsp_bus.hit, rsp_bus.read_value, rsp_bus.evicted, rsp_bus.evicted_key);
          fail_count++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_bus.hit !== want.hit) begin
            $error("hit: expected %b, got %b", want.hit, rsp_bus.hit);
            fail_count++;
          end
          if (rsp_bus.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, rsp_bus.read_value);
            fail_count++;
          end
          if (rsp_bus.evicted !== want.evicted) begin
            $error("evicted: expected %b, got %b", want.evicted, rsp_bus.evicted);
            fail_count++;
          end
          if (rsp_bus.evicted_key !== want.evicted_key) begin
            $error("evicted_key: expected %h, got %h", want.evicted_key, rsp_bus.evicted_key);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    wait (rst_ni);
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk_i);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [KEY_W-1:0]              key_pool [32];
    logic [KEY_W-1:0]              key;
    int unsigned                   pool_n;
    lkvc_pkg::op_e                 op;
    logic [lkvc_pkg::CAP_BITS-1:0] phase_cap;

    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    req_bus.valid       = 1'b0;
    req_bus.opcode      = lkvc_pkg::OP_GET;
    req_bus.lookup_key  = '0;
    req_bus.write_value = '0;
    rsp_bus.ready       = 1'b0;
    fail_count   = 0;
    quiet_cycles = 0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      line_valid[i] = 1'b0;
      line_key[i]   = '0;
      line_value[i] = '0;
      line_rank[i]  = 0;
    end
    lines_used = 0;
    cap_reg    = lkvc_pkg::CAP_RESET;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < ROWS; r++) begin
      if (DIRECTED[r].set_cap) write_capacity(DIRECTED[r].cap);
      issue_request(DIRECTED[r].op, DIRECTED[r].key, DIRECTED[r].wval,
                    DIRECTED[r].fixed, DIRECTED[r].fixed_rsp);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_cap = 5'd1;
        1:       phase_cap = 5'd16;
        2:       phase_cap = 5'd0;
        3:       phase_cap = 5'd31;
        4:       phase_cap = 5'd2;
        7:       phase_cap = 5'($urandom_range(1, 16));
        default: phase_cap = 5'($urandom_range(0, 31));
      endcase
      write_capacity(phase_cap);
      // no back-pressure or gaps for one whole phase
      idle_on = (p != 3);
      pool_n = ((phase_cap == 0) ? 1 : ((phase_cap > ENTRIES) ? ENTRIES : phase_cap))
               + $urandom_range(1, 6);
      if (pool_n > 32) pool_n = 32;
      for (int k = 0; k < pool_n; k++) key_pool[k] = 16'($urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 30) hold_req = 1'b1;
        if ($urandom_range(9) == 0) key = 16'($urandom);
        else key = key_pool[$urandom_range(pool_n - 1)];
        op = ($urandom_range(99) < 45) ? lkvc_pkg::OP_GET : lkvc_pkg::OP_PUT;
        issue_request(op, key, pick_value(), 1'b0, NO_RSP);
      end
    end

    idle_on = 1'b1;
    drain_responses();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/lkvc_pkg.sv
sv/lkvc_if.sv
sv/lkvc_lookup.sv
sv/lru_key_value_cache.sv
sv/lkvc_checker.sv
verif/tb_lru_key_value_cache.sv
